FILE: rtl/sha1_hash_engine_unit_macros.svh
// ----------------------------------------------------------------------------
// SHA-1 hash engine assertion macros
// Short forms for the concurrent checks of the engine, clocked on aclk and
// held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef SHA1_HASH_ENGINE_UNIT_MACROS_SVH
`define SHA1_HASH_ENGINE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SHE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sha1he_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 hash engine package
// Beat types, block command types and the fixed constants of SHA-1.
// ----------------------------------------------------------------------------
package sha1he_pkg;

    // Two block buffers of sixteen 32-bit words each.
    localparam int WORDS_PER_BLK = 16;
    localparam int BUF_COUNT     = 2;
    localparam int RAM_DEPTH     = WORDS_PER_BLK * BUF_COUNT;
    localparam int RAM_ADDR_W    = $clog2(RAM_DEPTH);

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [31:0] SHA1_IV [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] SHA1_K [4] = '{
        32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] digest_word0;
        logic [31:0] digest_word1;
        logic [31:0] digest_word2;
        logic [31:0] digest_word3;
        logic [31:0] digest_word4;
    } out_beat_t;

    // One full block waiting in a buffer.
    typedef struct packed {
        logic buf_sel;
        logic final_blk;
    } blk_cmd_t;

    // The compression side has copied a buffer out and hands it back.
    typedef struct packed {
        logic valid;
        logic buf_sel;
    } blk_rel_t;

endpackage

FILE: rtl/sha1he_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sha1he_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/sha1he_front.sv
// ----------------------------------------------------------------------------
// SHA-1 byte front end
// Packs message bytes into words, appends the padding and the bit count, and
// hands each full block buffer to the compression side.
// ----------------------------------------------------------------------------
module sha1he_front
    import sha1he_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_beat_t              s_data,
    output logic                  wr_en,
    output logic [RAM_ADDR_W-1:0] wr_addr,
    output logic [31:0]           wr_data,
    output logic                  cmd_push,
    output blk_cmd_t              cmd_data,
    input  logic                  cmd_room,
    input  blk_rel_t              rel
);

    typedef enum logic [1:0] {ST_DATA, ST_MARK, ST_ZERO, ST_LEN} state_t;

    state_t                 state_reg, state_next;
    logic [5:0]             fill_reg, fill_next;
    logic                   wbuf_reg, wbuf_next;
    logic [BUF_COUNT-1:0]   busy_reg, busy_next;
    logic [23:0]            word_reg, word_next;
    logic [60:0]            count_reg, count_next;

    logic                   slot_free;
    logic                   push_en;
    logic [7:0]             push_byte;
    logic                   blk_end;
    logic [63:0]            bit_len;

    assign slot_free = !busy_reg[wbuf_reg] && cmd_room;
    assign s_ready   = (state_reg == ST_DATA) && slot_free;
    assign bit_len   = {count_reg, 3'b000};

    always_comb begin
        push_en   = slot_free;
        push_byte = 8'h00;
        unique case (state_reg)
            ST_DATA: begin
                push_en   = s_valid && slot_free;
                push_byte = s_data.data_byte;
            end
            ST_MARK: push_byte = PAD_MARK;
            ST_ZERO: push_byte = 8'h00;
            ST_LEN:  push_byte = bit_len[{~fill_reg[2:0], 3'b000} +: 8];
            default: push_byte = 8'h00;
        endcase
    end

    assign blk_end = push_en && (fill_reg == 6'd63);
    assign wr_en   = push_en && (fill_reg[1:0] == 2'b11);
    assign wr_addr = {wbuf_reg, fill_reg[5:2]};
    assign wr_data = {word_reg, push_byte};

    always_comb begin
        cmd_push           = blk_end;
        cmd_data.buf_sel   = wbuf_reg;
        cmd_data.final_blk = (state_reg == ST_LEN);
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        fill_next  = push_en ? fill_reg + 6'd1 : fill_reg;
        word_next  = push_en ? {word_reg[15:0], push_byte} : word_reg;
        wbuf_next  = blk_end ? !wbuf_reg : wbuf_reg;

        busy_next = busy_reg;
        if (rel.valid) begin
            busy_next[rel.buf_sel] = 1'b0;
        end
        if (blk_end) begin
            busy_next[wbuf_reg] = 1'b1;
        end

        unique case (state_reg)
            ST_DATA: begin
                if (push_en) begin
                    count_next = count_reg + 61'd1;
                    if (s_data.last_byte) begin
                        state_next = ST_MARK;
                    end
                end
            end
            ST_MARK: begin
                if (push_en) begin
                    state_next = (fill_reg == 6'd55) ? ST_LEN : ST_ZERO;
                end
            end
            ST_ZERO: begin
                if (push_en && (fill_reg == 6'd55)) begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN: begin
                if (blk_end) begin
                    state_next = ST_DATA;
                    count_next = '0;
                end
            end
            default: state_next = ST_DATA;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_DATA;
            fill_reg  <= '0;
            wbuf_reg  <= 1'b0;
            busy_reg  <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            wbuf_reg  <= wbuf_next;
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
        word_reg <= word_next;
    end

endmodule

FILE: rtl/sha1he_cmd_queue.sv
// ----------------------------------------------------------------------------
// SHA-1 block command queue
// Two-entry queue of block commands between the front end and the
// compression side.
// ----------------------------------------------------------------------------
module sha1he_cmd_queue
    import sha1he_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  blk_cmd_t push_data,
    output logic     room,
    input  logic     pop,
    output logic     avail,
    output blk_cmd_t pop_data
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    blk_cmd_t         ent_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] rptr_reg;
    logic [PTR_W:0]   cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign room     = (cnt_reg != (PTR_W+1)'(DEPTH));
    assign avail    = (cnt_reg != '0);
    assign pop_data = ent_reg[rptr_reg];
    assign do_push  = push && room;
    assign do_pop   = pop && avail;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (do_push) begin
                wptr_reg <= wptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rptr_reg <= rptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + (PTR_W+1)'(1);
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - (PTR_W+1)'(1);
            end
        end
        if (do_push) begin
            ent_reg[wptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/sha1he_back.sv
// ----------------------------------------------------------------------------
// SHA-1 compression back end
// Copies a block into the message schedule window, runs the 80 rounds one a
// cycle, folds the result into the chaining words and registers the digest.
// ----------------------------------------------------------------------------
module sha1he_back
    import sha1he_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_avail,
    input  blk_cmd_t              q_data,
    output logic                  q_pop,
    output logic [RAM_ADDR_W-1:0] rd_addr,
    input  logic [31:0]           rd_data,
    output blk_rel_t              rel,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_beat_t             m_data
);

    typedef enum logic [1:0] {B_IDLE, B_LOAD, B_ROUND, B_DONE} state_t;

    state_t      state_reg;
    logic        cur_buf_reg;
    logic        cur_final_reg;
    logic [4:0]  cnt_reg;
    logic [6:0]  rnd_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] chain_reg [5];
    logic [31:0] w_reg [WORDS_PER_BLK];
    logic        m_valid_reg;
    out_beat_t   m_data_reg;

    logic [1:0]  stage;
    logic [31:0] f_val;
    logic [31:0] round_sum;
    logic [31:0] sched_mix;
    logic [31:0] sched_new;
    logic [31:0] sum_w [5];
    logic        out_free;

    assign q_pop       = (state_reg == B_IDLE) && q_avail;
    assign rd_addr     = {cur_buf_reg, cnt_reg[3:0]};
    assign rel.valid   = (state_reg == B_LOAD) && (cnt_reg == 5'd16);
    assign rel.buf_sel = cur_buf_reg;
    assign m_valid     = m_valid_reg;
    assign m_data      = m_data_reg;
    assign out_free    = !m_valid_reg || m_ready;

    always_comb begin
        if (rnd_reg < 7'd20) begin
            stage = 2'd0;
        end else if (rnd_reg < 7'd40) begin
            stage = 2'd1;
        end else if (rnd_reg < 7'd60) begin
            stage = 2'd2;
        end else begin
            stage = 2'd3;
        end
        case (stage)
            2'd0:    f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd2:    f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            default: f_val = b_reg ^ c_reg ^ d_reg;
        endcase
        round_sum = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + SHA1_K[stage] + w_reg[0];
        sched_mix = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        sched_new = {sched_mix[30:0], sched_mix[31]};
        sum_w[0]  = chain_reg[0] + a_reg;
        sum_w[1]  = chain_reg[1] + b_reg;
        sum_w[2]  = chain_reg[2] + c_reg;
        sum_w[3]  = chain_reg[3] + d_reg;
        sum_w[4]  = chain_reg[4] + e_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 5; i++) begin
                chain_reg[i] <= SHA1_IV[i];
            end
        end else begin
            if ((state_reg == B_DONE) && cur_final_reg && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE: begin
                    if (q_avail) begin
                        state_reg <= B_LOAD;
                    end
                end
                B_LOAD: begin
                    if (cnt_reg == 5'd16) begin
                        state_reg <= B_ROUND;
                    end
                end
                B_ROUND: begin
                    if (rnd_reg == 7'd79) begin
                        state_reg <= B_DONE;
                    end
                end
                B_DONE: begin
                    if (!cur_final_reg) begin
                        for (int i = 0; i < 5; i++) begin
                            chain_reg[i] <= sum_w[i];
                        end
                        state_reg <= B_IDLE;
                    end else if (out_free) begin
                        for (int i = 0; i < 5; i++) begin
                            chain_reg[i] <= SHA1_IV[i];
                        end
                        state_reg <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end

        // Datapath registers carry no reset.
        unique case (state_reg)
            B_IDLE: begin
                cur_buf_reg   <= q_data.buf_sel;
                cur_final_reg <= q_data.final_blk;
                cnt_reg       <= '0;
                rnd_reg       <= '0;
                a_reg         <= chain_reg[0];
                b_reg         <= chain_reg[1];
                c_reg         <= chain_reg[2];
                d_reg         <= chain_reg[3];
                e_reg         <= chain_reg[4];
            end
            B_LOAD: begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg != 5'd0) begin
                    for (int i = 0; i < WORDS_PER_BLK - 1; i++) begin
                        w_reg[i] <= w_reg[i+1];
                    end
                    w_reg[WORDS_PER_BLK-1] <= rd_data;
                end
            end
            B_ROUND: begin
                rnd_reg <= rnd_reg + 7'd1;
                a_reg   <= round_sum;
                b_reg   <= a_reg;
                c_reg   <= {b_reg[1:0], b_reg[31:2]};
                d_reg   <= c_reg;
                e_reg   <= d_reg;
                for (int i = 0; i < WORDS_PER_BLK - 1; i++) begin
                    w_reg[i] <= w_reg[i+1];
                end
                w_reg[WORDS_PER_BLK-1] <= sched_new;
            end
            B_DONE: begin
                if (cur_final_reg && out_free) begin
                    m_data_reg.digest_word0 <= sum_w[0];
                    m_data_reg.digest_word1 <= sum_w[1];
                    m_data_reg.digest_word2 <= sum_w[2];
                    m_data_reg.digest_word3 <= sum_w[3];
                    m_data_reg.digest_word4 <= sum_w[4];
                end
            end
            default: cnt_reg <= '0;
        endcase
    end

endmodule

FILE: rtl/sha1_hash_engine_unit.sv
// ----------------------------------------------------------------------------
// SHA-1 hash engine
// Streams message bytes in, returns one 160-bit SHA-1 digest per message.
// ----------------------------------------------------------------------------
// Usage
// The input channel (s_valid, s_ready, s_data) takes one message byte per beat;
// s_data.last_byte marks the final byte of a message. Every message has at
// least one byte. The output channel (m_valid, m_ready, m_data) delivers one
// beat per message carrying the digest as five big-endian words.
// The front end accepts one byte per cycle, while a buffer and a queue slot
// are free, into one of two 64-byte block buffers. A full buffer is queued for
// the compression unit, which takes the block command, copies the sixteen
// words out of the block RAM through its registered read port, runs 80 rounds
// at one per cycle and folds the result into the chaining words. A buffer is
// handed back to the front end as soon as its words are copied out.
// After the last byte the front end writes the padding and the bit count
// itself, 9 to 72 bytes, one byte per cycle while a buffer and a queue slot
// are free. The digest beat is registered from the final block's sum with the
// chaining words.
// Reset (aresetn low at a clock edge) empties both buffers and the queue,
// drops any pending digest and restores the initial chaining words.
// When the receiver stalls, the digest waits in the output register; the
// compression side holds once it has finished its next final block, and the
// byte side keeps accepting until both buffers are full.
// ----------------------------------------------------------------------------
`include "sha1_hash_engine_unit_macros.svh"

module sha1_hash_engine_unit
    import sha1he_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    // Block RAM ports: the front end writes packed words, the back end reads.
    logic                  ram_wr_en;
    logic [RAM_ADDR_W-1:0] ram_wr_addr;
    logic [31:0]           ram_wr_data;
    logic [RAM_ADDR_W-1:0] ram_rd_addr;
    logic [31:0]           ram_rd_data;

    // Block commands and buffer hand-back between the two halves.
    logic                  cmd_push;
    blk_cmd_t              cmd_data;
    logic                  cmd_room;
    logic                  cmd_pop;
    logic                  cmd_avail;
    blk_cmd_t              cmd_head;
    blk_rel_t              rel;

    sha1he_ram #(
        .WIDTH (32),
        .DEPTH (RAM_DEPTH)
    ) u_block_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    sha1he_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .wr_en    (ram_wr_en),
        .wr_addr  (ram_wr_addr),
        .wr_data  (ram_wr_data),
        .cmd_push (cmd_push),
        .cmd_data (cmd_data),
        .cmd_room (cmd_room),
        .rel      (rel)
    );

    sha1he_cmd_queue u_cmd_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (cmd_push),
        .push_data (cmd_data),
        .room      (cmd_room),
        .pop       (cmd_pop),
        .avail     (cmd_avail),
        .pop_data  (cmd_head)
    );

    sha1he_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_avail  (cmd_avail),
        .q_data   (cmd_head),
        .q_pop    (cmd_pop),
        .rd_addr  (ram_rd_addr),
        .rd_data  (ram_rd_data),
        .rel      (rel),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // A block is only handed over while the queue has a free slot.
    `SHE_ASSERT_NOW(a_queue_room, cmd_push, cmd_room, "block command pushed into a full queue")

    // The buffer being handed back can never be the one just filled.
    `SHE_ASSERT_NOW(a_release_other, rel.valid && cmd_push, rel.buf_sel != cmd_data.buf_sel, "released buffer equals the buffer being committed")

    // Once a buffer is copied out the rounds start, so no command is taken next.
    `SHE_ASSERT_NEXT(a_rounds_follow, rel.valid, !cmd_pop, "block command taken while rounds should be running")

endmodule
